// ===== design/stbs_pkg.sv =====
// Shared constants and types for the sorted table search block.
package stbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int ELEM_W      = 32;
    localparam int POS_W       = 10;
    localparam int MODE_W      = 2;
    localparam int M_TDATA_W   = ((POS_W + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 2'd0,
        MODE_CLEAR  = 2'd1,
        MODE_LINEAR = 2'd2,
        MODE_BINARY = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LIN,
        ST_BIN_RD,
        ST_BIN_CMP
    } state_t;

endpackage

// ===== design/stbs_ram.sv =====
// Generic simple dual-port RAM, one write port and one registered read port.
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/sorted_table_linear_binary_search_top.sv =====
// Sorted table search block: element store with linear and binary lookup.
//
// The block keeps up to TABLE_DEPTH signed 32-bit elements in one simple
// dual-port RAM (registered read) plus an element count. Each input
// transfer carries a mode in s_tuser and a value in s_tdata. Append
// (mode 0) writes the value at index count; it is dropped when the table
// is full. Clear (mode 1) zeroes the count. Neither produces a result.
// Linear search (mode 2) streams reads from index 0 up, one per cycle,
// comparing each returned word against the key. Binary search (mode 3)
// probes mid = low + (high-low)/2 with a read state and a compare state
// per probe. Both searches are bound by the single RAM read port. One
// item is worked on at a time; s_tready is high only between items. Each
// search returns exactly one result transfer: m_tuser is the found flag
// and m_tdata holds the position (zero on a miss). The result sits in an
// output register, so a new item is taken while the previous result still
// waits for m_tready; a search that finishes while that register is still
// full holds until it drains.
module sorted_table_linear_binary_search_top
    import stbs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [ELEM_W-1:0]    s_tdata,   // [31:0] value (signed)
    input  logic [MODE_W-1:0]    s_tuser,   // [1:0] mode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [9:0] position, rest zero
    output logic                 m_tuser    // [0] found
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ELEM_W-1:0]  key_reg, key_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;       // linear: next read index
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic               pend_reg, pend_next;     // linear: a read is in flight
    logic [CNT_W-1:0]   low_reg, low_next;       // binary: low
    logic [CNT_W-1:0]   hi1_reg, hi1_next;       // binary: high + 1
    logic [CNT_W-1:0]   mid_reg, mid_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_found_reg, m_found_next;
    logic [POS_W-1:0]   m_pos_reg, m_pos_next;

    logic               wr_en;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ELEM_W-1:0]  rd_data;
    logic               accept;
    logic               out_free;
    logic               lin_hit;
    logic [CNT_W-1:0]   span;
    logic [CNT_W-1:0]   mid_calc;

    stbs_ram #(
        .WIDTH(ELEM_W),
        .DEPTH(TABLE_DEPTH)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(count_reg[IDX_W-1:0]),
        .wr_data(s_tdata),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign lin_hit  = pend_reg && (rd_data == key_reg);
    assign span     = hi1_reg - low_reg - CNT_W'(1);
    assign mid_calc = low_reg + (span >> 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg      <= key_next;
        idx_reg      <= idx_next;
        pend_idx_reg <= pend_idx_next;
        low_reg      <= low_next;
        hi1_reg      <= hi1_next;
        mid_reg      <= mid_next;
        m_found_reg  <= m_found_next;
        m_pos_reg    <= m_pos_next;
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        key_next      = key_reg;
        idx_next      = idx_reg;
        pend_idx_next = pend_idx_reg;
        pend_next     = pend_reg;
        low_next      = low_reg;
        hi1_next      = hi1_reg;
        mid_next      = mid_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_found_next  = m_found_reg;
        m_pos_next    = m_pos_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = idx_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    key_next = s_tdata;
                    case (mode_t'(s_tuser))
                        MODE_APPEND: begin
                            if (count_reg < CNT_W'(TABLE_DEPTH)) begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        MODE_CLEAR: begin
                            count_next = '0;
                        end
                        MODE_LINEAR: begin
                            idx_next   = '0;
                            pend_next  = 1'b0;
                            state_next = ST_LIN;
                        end
                        MODE_BINARY: begin
                            low_next   = '0;
                            hi1_next   = count_reg;
                            state_next = ST_BIN_RD;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_LIN: begin
                // Compare the last read word, else issue the next read.
                if (lin_hit) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_found_next = 1'b1;
                        m_pos_next   = POS_W'(pend_idx_reg);
                        pend_next    = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end else if (idx_reg < count_reg) begin
                    rd_en         = 1'b1;
                    rd_addr       = idx_reg[IDX_W-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[IDX_W-1:0];
                    idx_next      = idx_reg + CNT_W'(1);
                end else begin
                    pend_next = 1'b0;
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_found_next = 1'b0;
                        m_pos_next   = '0;
                        state_next   = ST_IDLE;
                    end
                end
            end

            ST_BIN_RD: begin
                if (low_reg < hi1_reg) begin
                    rd_en      = 1'b1;
                    rd_addr    = mid_calc[IDX_W-1:0];
                    mid_next   = mid_calc;
                    state_next = ST_BIN_CMP;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_found_next = 1'b0;
                    m_pos_next   = '0;
                    state_next   = ST_IDLE;
                end
            end

            ST_BIN_CMP: begin
                if (rd_data == key_reg) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_found_next = 1'b1;
                        m_pos_next   = POS_W'(mid_reg);
                        state_next   = ST_IDLE;
                    end
                end else if ($signed(rd_data) < $signed(key_reg)) begin
                    low_next   = mid_reg + CNT_W'(1);
                    state_next = ST_BIN_RD;
                end else begin
                    hi1_next   = mid_reg;
                    state_next = ST_BIN_RD;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = M_TDATA_W'(m_pos_reg);

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("element count beyond table depth");

    a_miss_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_pos_reg == '0))
        else $error("miss result with nonzero position");

    a_probe_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BIN_CMP) |-> (mid_reg < count_reg))
        else $error("binary probe outside filled range");

    a_result_on_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE && state_next == ST_IDLE) |-> out_free)
        else $error("search finished into a full output register");
`endif

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the sorted table search block: stream stimulus and a lookup predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stbs_pkg::*;

    localparam int RANDOM_ITEMS = 80;
    localparam int TAIL_ITEMS   = 150;      // no idling on either side for the last items
    localparam int HOLD_AT      = 60;       // accepted transfers before the long output hold-off
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_WAIT   = 1100;     // covers a linear scan of a full table
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct {
        mode_t                mode;
        logic [ELEM_W-1:0]    value;
        bit                   drain_first;  // sender waits for every result before offering
    } table_item_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } lookup_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [ELEM_W-1:0]    s_tdata  = '0;
    logic [MODE_W-1:0]    s_tuser  = MODE_APPEND;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    table_item_t       pending_items[$];
    lookup_t           pending_lookups[$];
    logic [ELEM_W-1:0] gen_keys[$];         // what the stimulus has put in the table so far

    logic [ELEM_W-1:0] elem_mem [TABLE_DEPTH];
    int                elem_count   = 0;

    int  item_total     = 0;
    int  accepted_count = 0;
    int  results_seen   = 0;
    int  fail_count     = 0;
    int  cycle_count    = 0;
    int  idle_pct       = 0;
    int  gap_left       = 0;
    int  stall_left     = 0;
    int  hold_left      = 0;
    bit  hold_done      = 1'b0;
    bit  in_fire        = 1'b0;
    bit  tail_phase     = 1'b0;

    sorted_table_linear_binary_search_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Table behavior: updates the shadow store and returns the lookup a search yields.
    function automatic void search_table_apply(input mode_t mode, input logic [ELEM_W-1:0] key,
                                               output bit has_result, output lookup_t res);
        int lo;
        int hi;
        int mid;
        res        = '0;
        has_result = 1'b0;
        case (mode)
            MODE_APPEND: begin
                if (elem_count < TABLE_DEPTH) begin
                    elem_mem[elem_count] = key;
                    elem_count++;
                end
            end
            MODE_CLEAR: elem_count = 0;
            MODE_LINEAR: begin
                has_result = 1'b1;
                for (int i = 0; i < elem_count; i++) begin
                    if (elem_mem[i] == key) begin
                        res.found    = 1'b1;
                        res.position = POS_W'(i);
                        break;
                    end
                end
            end
            MODE_BINARY: begin
                has_result = 1'b1;
                lo = 0;
                hi = elem_count - 1;
                while (lo <= hi && !res.found) begin
                    mid = lo + (hi - lo) / 2;
                    if (elem_mem[mid] == key) begin
                        res.found    = 1'b1;
                        res.position = POS_W'(mid);
                    end else if ($signed(elem_mem[mid]) < $signed(key)) begin
                        lo = mid + 1;
                    end else begin
                        hi = mid - 1;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic queue_item(input mode_t mode, input logic [ELEM_W-1:0] value, input bit drain);
        table_item_t it;
        it.mode        = mode;
        it.value       = value;
        it.drain_first = drain;
        pending_items.push_back(it);
        if (mode == MODE_APPEND && gen_keys.size() < TABLE_DEPTH)
            gen_keys.push_back(value);
        else if (mode == MODE_CLEAR)
            gen_keys.delete();
    endtask

    // Mostly keys present in the table, some neighbors of them, some anything.
    function automatic logic [ELEM_W-1:0] pick_key();
        logic [ELEM_W-1:0] k;
        int                roll;
        roll = $urandom_range(0, 99);
        if (gen_keys.size() == 0 || roll < 25) begin
            k = $urandom();
        end else begin
            k = gen_keys[$urandom_range(0, gen_keys.size() - 1)];
            if (roll < 40)
                k = roll[0] ? k + 1 : k - 1;
        end
        return k;
    endfunction

    // Clear, fill with a fresh table, then search it.
    task automatic queue_table_run(input bit sorted, input bit drain);
        int vals[$];
        int n;
        bit narrow;
        n      = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 40);
        narrow = ($urandom_range(0, 3) == 0);   // small range gives duplicates
        queue_item(MODE_CLEAR, $urandom(), drain);
        repeat (n) vals.push_back(narrow ? int'($urandom_range(0, 16)) - 8 : int'($urandom()));
        if (sorted)
            vals.sort();
        foreach (vals[i])
            queue_item(MODE_APPEND, vals[i], 1'b0);
        repeat ($urandom_range(2, 8))
            queue_item(mode_t'($urandom_range(0, 1) ? MODE_LINEAR : MODE_BINARY),
                       pick_key(), 1'b0);
    endtask

    initial begin
        int                vals[$];
        logic [ELEM_W-1:0] extra;
        int                random_start;
        int                seq_no;
        int                pick;
        mode_t             mode;

        // Directed: empty table, signed extremes, duplicates, unsorted binary probe.
        queue_item(MODE_LINEAR, 32'h0000_0000, 1'b0);
        queue_item(MODE_BINARY, 32'hFFFF_FFFF, 1'b0);
        queue_item(MODE_APPEND, 32'h8000_0000, 1'b0);
        queue_item(MODE_APPEND, 32'hFFFF_FFFF, 1'b0);
        queue_item(MODE_APPEND, 32'h0000_0000, 1'b0);
        queue_item(MODE_APPEND, 32'h0000_0001, 1'b0);
        queue_item(MODE_APPEND, 32'h7FFF_FFFF, 1'b0);
        queue_item(MODE_LINEAR, 32'h8000_0000, 1'b0);
        queue_item(MODE_LINEAR, 32'h7FFF_FFFF, 1'b0);
        queue_item(MODE_BINARY, 32'hFFFF_FFFF, 1'b0);
        queue_item(MODE_BINARY, 32'h8000_0000, 1'b0);
        queue_item(MODE_BINARY, 32'h7FFF_FFFF, 1'b0);
        queue_item(MODE_BINARY, 32'h0000_0002, 1'b0);
        queue_item(MODE_CLEAR,  32'hFFFF_FFFF, 1'b0);
        repeat (5) queue_item(MODE_APPEND, 32'h0000_0003, 1'b0);
        queue_item(MODE_BINARY, 32'h0000_0003, 1'b0);
        queue_item(MODE_LINEAR, 32'h0000_0003, 1'b0);
        queue_item(MODE_CLEAR,  32'h0000_0000, 1'b0);
        queue_item(MODE_APPEND, 32'd9, 1'b0);
        queue_item(MODE_APPEND, 32'd1, 1'b0);
        queue_item(MODE_APPEND, 32'd5, 1'b0);
        queue_item(MODE_BINARY, 32'd9, 1'b0);
        queue_item(MODE_LINEAR, 32'd9, 1'b0);

        // Random: mostly fresh tables with searches, the rest noise on a bounded table.
        random_start = pending_items.size();
        seq_no       = 0;
        while (pending_items.size() - random_start < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                queue_table_run(1'b1, seq_no % 12 == 0);
            end else if (pick < 75) begin
                queue_table_run(1'b0, seq_no % 12 == 0);
            end else begin
                repeat ($urandom_range(4, 16)) begin
                    mode = mode_t'($urandom_range(0, 3));
                    if (mode == MODE_APPEND && gen_keys.size() >= 48)
                        mode = MODE_CLEAR;
                    queue_item(mode, (mode == MODE_APPEND || $urandom_range(0, 1)) ?
                               $urandom() : pick_key(), 1'b0);
                end
            end
            seq_no++;
        end

        // Full table: sorted fill, appends past capacity, searches reaching the top index.
        for (int i = 0; i < TABLE_DEPTH; i++)
            vals.push_back($urandom());
        vals.sort();
        queue_item(MODE_CLEAR, $urandom(), 1'b1);
        foreach (vals[i])
            queue_item(MODE_APPEND, vals[i], 1'b0);
        extra = $urandom();
        queue_item(MODE_APPEND, $urandom(), 1'b0);
        queue_item(MODE_APPEND, extra, 1'b0);
        queue_item(MODE_LINEAR, vals[TABLE_DEPTH-1], 1'b0);
        queue_item(MODE_LINEAR, extra, 1'b0);
        queue_item(MODE_LINEAR, vals[$urandom_range(0, TABLE_DEPTH - 1)], 1'b0);
        queue_item(MODE_BINARY, vals[TABLE_DEPTH-1], 1'b0);
        queue_item(MODE_BINARY, vals[0], 1'b0);
        repeat (10) queue_item(MODE_BINARY, pick_key(), 1'b0);
        item_total = pending_items.size();

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (accepted_count != item_total || pending_lookups.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (fail_count == 0 && pending_lookups.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Sender: holds an item until its transfer, idles in bursts.
    always @(negedge aclk) begin
        bit          next_valid;
        table_item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
        end else begin
            next_valid = s_tvalid && !in_fire;
            if (!next_valid) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                end else if (pending_items.size() != 0 &&
                             !(pending_items[0].drain_first && pending_lookups.size() != 0)) begin
                    if (!tail_phase && $urandom_range(0, 99) < idle_pct) begin
                        gap_left <= $urandom_range(0, 12);
                    end else begin
                        it         = pending_items.pop_front();
                        s_tdata   <= it.value;
                        s_tuser   <= it.mode;
                        next_valid = 1'b1;
                    end
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // Long receiver hold-off, once, so the block backs up into its input.
    always @(negedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && accepted_count >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!tail_phase && $urandom_range(0, 99) < idle_pct) begin
            stall_left <= $urandom_range(0, 12);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Both channels sampled at the rising edge: predict on input transfers, check outputs.
    always @(posedge aclk) begin
        bit      has_result;
        lookup_t want;
        if (!aresetn) begin
            in_fire    <= 1'b0;
            tail_phase <= 1'b0;
        end else begin
            in_fire    <= s_tvalid && s_tready;
            tail_phase <= (accepted_count + TAIL_ITEMS >= item_total);
            if (s_tvalid && s_tready) begin
                search_table_apply(mode_t'(s_tuser), s_tdata, has_result, want);
                if (has_result)
                    pending_lookups.push_back(want);
                accepted_count <= accepted_count + 1;
            end
            if (m_tvalid && m_tready) begin
                if (pending_lookups.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result %0d unexpected: found=%0b m_tdata=%0d",
                                 results_seen, m_tuser, m_tdata);
                end else begin
                    want = pending_lookups.pop_front();
                    if (m_tuser !== want.found || m_tdata !== M_TDATA_W'(want.position)) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result %0d mismatch: expected found=%0b position=%0d,",
                                     results_seen, want.found, want.position,
                                     " got found=%0b m_tdata=%0d", m_tuser, m_tdata);
                    end
                end
                results_seen++;
            end
        end
    end

    // Cycle budget and the idling mix, which is reshuffled periodically.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 200 == 0) begin
            case ($urandom_range(0, 2))
                0:       idle_pct <= 0;
                1:       idle_pct <= 15;
                default: idle_pct <= 40;
            endcase
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
design/stbs_pkg.sv
design/stbs_ram.sv
design/sorted_table_linear_binary_search_top.sv
sim/tb.sv
